// ===== design/complex_arithmetic_unit_defines.svh =====
// Assertion macros shared by the complex arithmetic unit RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define CAU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cau_pkg.sv =====
// Types and constants of the complex arithmetic unit.
// No dependencies; used by every module of the block.
package cau_pkg;

	localparam int WORD_BITS     = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PROD_BITS     = 2 * WORD_BITS;
	localparam int WIDE_BITS     = 2 * WORD_BITS + 1;

	typedef enum logic [2:0] {
		ACT_ADD   = 3'd0,
		ACT_SUB   = 3'd1,
		ACT_MUL   = 3'd2,
		ACT_DIV   = 3'd3,
		ACT_SQR   = 3'd4,
		ACT_RECIP = 3'd5,
		ACT_NEG   = 3'd6,
		ACT_CMP   = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DZERO = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	typedef struct packed {
		action_t                       action;
		logic signed [WORD_BITS-1:0]   a_re;
		logic signed [WORD_BITS-1:0]   a_im;
		logic signed [WORD_BITS-1:0]   b_re;
		logic signed [WORD_BITS-1:0]   b_im;
	} cau_in_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0]   r_re;
		logic signed [WORD_BITS-1:0]   r_im;
		status_t                       status;
		logic                          equal;
	} cau_out_t;

	// Front end to divider: exact wide values and divide operands.
	typedef struct packed {
		logic                          is_div;
		logic                          recip;
		logic                          dz;
		logic                          equal;
		logic signed [WIDE_BITS-1:0]   wre;
		logic signed [WIDE_BITS-1:0]   wim;
		logic signed [WIDE_BITS-1:0]   nre;
		logic signed [WIDE_BITS-1:0]   nim;
		logic [PROD_BITS-1:0]          d;
	} cau_fe_t;

	// Result already final unless is_div is set.
	typedef struct packed {
		logic                          is_div;
		logic [WORD_BITS-1:0]          re;
		logic [WORD_BITS-1:0]          im;
		status_t                       status;
		logic                          equal;
	} cau_side_t;

	typedef struct packed {
		logic                          neg_re;
		logic                          neg_im;
		logic                          ovf_re;
		logic                          ovf_im;
		logic [WORD_BITS:0]            q_re;
		logic [WORD_BITS:0]            q_im;
	} cau_qt_t;

endpackage

// ===== design/cau_front.sv =====
// Front end: operand select, products and exact sums (stages 1 to 3).
// Depends on cau_pkg.
module cau_front #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  cau_pkg::cau_in_t  in_data,
	output logic              out_valid,
	output cau_pkg::cau_fe_t  out_data
);

	localparam int W  = cau_pkg::WORD_BITS;
	localparam int PB = cau_pkg::PROD_BITS;
	localparam int WB = cau_pkg::WIDE_BITS;

	// stage 0 logic
	logic signed [W:0]   sre0, sim0;
	logic signed [W-1:0] yre0, yim0, ure0, uim0;
	logic                eq0;

	always_comb begin
		sre0 = '0;
		sim0 = '0;
		case (in_data.action)
			cau_pkg::ACT_ADD: begin
				sre0 = (W+1)'(in_data.a_re) + (W+1)'(in_data.b_re);
				sim0 = (W+1)'(in_data.a_im) + (W+1)'(in_data.b_im);
			end
			cau_pkg::ACT_SUB: begin
				sre0 = (W+1)'(in_data.a_re) - (W+1)'(in_data.b_re);
				sim0 = (W+1)'(in_data.a_im) - (W+1)'(in_data.b_im);
			end
			cau_pkg::ACT_NEG: begin
				sre0 = -(W+1)'(in_data.a_re);
				sim0 = -(W+1)'(in_data.a_im);
			end
			default: begin
				sre0 = '0;
				sim0 = '0;
			end
		endcase
		yre0 = (in_data.action == cau_pkg::ACT_SQR) ? in_data.a_re : in_data.b_re;
		yim0 = (in_data.action == cau_pkg::ACT_SQR) ? in_data.a_im : in_data.b_im;
		ure0 = (in_data.action == cau_pkg::ACT_RECIP) ? in_data.a_re : in_data.b_re;
		uim0 = (in_data.action == cau_pkg::ACT_RECIP) ? in_data.a_im : in_data.b_im;
		eq0  = (in_data.action == cau_pkg::ACT_CMP) && (in_data.a_re == in_data.b_re)
			&& (in_data.a_im == in_data.b_im);
	end

	logic                  v_s1, v_s2;
	cau_pkg::action_t      act_s1, act_s2;
	logic signed [W-1:0]   xre_s1, xim_s1, yre_s1, yim_s1, ure_s1, uim_s1;
	logic signed [W:0]     sre_s1, sim_s1, sre_s2, sim_s2;
	logic                  eq_s1, eq_s2;
	logic signed [W-1:0]   xre_s2, xim_s2;
	logic signed [PB-1:0]  prr_s2, pii_s2, pri_s2, pir_s2, dr_s2, di_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	// stage 1: operands
	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= in_data.action;
			xre_s1 <= in_data.a_re;
			xim_s1 <= in_data.a_im;
			yre_s1 <= yre0;
			yim_s1 <= yim0;
			ure_s1 <= ure0;
			uim_s1 <= uim0;
			sre_s1 <= sre0;
			sim_s1 <= sim0;
			eq_s1  <= eq0;
		end
	end

	// stage 2: six products
	always_ff @(posedge clk) begin
		if (en) begin
			act_s2 <= act_s1;
			sre_s2 <= sre_s1;
			sim_s2 <= sim_s1;
			eq_s2  <= eq_s1;
			xre_s2 <= xre_s1;
			xim_s2 <= xim_s1;
			prr_s2 <= PB'(xre_s1) * PB'(yre_s1);
			pii_s2 <= PB'(xim_s1) * PB'(yim_s1);
			pri_s2 <= PB'(xre_s1) * PB'(yim_s1);
			pir_s2 <= PB'(xim_s1) * PB'(yre_s1);
			dr_s2  <= PB'(ure_s1) * PB'(ure_s1);
			di_s2  <= PB'(uim_s1) * PB'(uim_s1);
		end
	end

	// stage 3: exact sums
	cau_pkg::cau_fe_t fe3;
	logic signed [WB-1:0] t_re, t_im;

	always_comb begin
		t_re = WB'(prr_s2) - WB'(pii_s2);
		t_im = WB'(pri_s2) + WB'(pir_s2);
		fe3.is_div = (act_s2 == cau_pkg::ACT_DIV) || (act_s2 == cau_pkg::ACT_RECIP);
		fe3.recip  = (act_s2 == cau_pkg::ACT_RECIP);
		fe3.equal  = eq_s2;
		fe3.d      = PB'(dr_s2) + PB'(di_s2);
		fe3.dz     = (fe3.d == '0);
		case (act_s2)
			cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_NEG: begin
				fe3.wre = WB'(sre_s2);
				fe3.wim = WB'(sim_s2);
			end
			cau_pkg::ACT_MUL, cau_pkg::ACT_SQR: begin
				fe3.wre = t_re >>> FRAC_BITS;
				fe3.wim = t_im >>> FRAC_BITS;
			end
			default: begin
				fe3.wre = '0;
				fe3.wim = '0;
			end
		endcase
		if (act_s2 == cau_pkg::ACT_RECIP) begin
			fe3.nre = WB'(xre_s2);
			fe3.nim = -WB'(xim_s2);
		end else begin
			fe3.nre = WB'(prr_s2) + WB'(pii_s2);
			fe3.nim = WB'(pir_s2) - WB'(pri_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= fe3;
		end
	end

endmodule

// ===== design/cau_div.sv =====
// Divider pipeline: setup stage, then one quotient bit per stage.
// Also saturates non-divide results into the sideband. Depends on cau_pkg.
module cau_div #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  cau_pkg::cau_fe_t    in_data,
	output logic                out_valid,
	output cau_pkg::cau_side_t  out_side,
	output cau_pkg::cau_qt_t    out_q
);

	localparam int W  = cau_pkg::WORD_BITS;
	localparam int PB = cau_pkg::PROD_BITS;
	localparam int WB = cau_pkg::WIDE_BITS;
	localparam int NS = W + 1;
	localparam int XW = PB + 2 * FRAC_BITS;
	localparam int HW = XW - W - 1;
	localparam int CW = (HW > PB) ? HW : PB;

	localparam logic signed [WB-1:0] MAXW = {{(W+2){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [WB-1:0] MINW = {{(W+2){1'b1}}, {(W-1){1'b0}}};
	localparam logic [W-1:0]         MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]         MINV = {1'b1, {(W-1){1'b0}}};

	// setup: magnitudes, scaled numerators, overflow precheck, saturation
	logic [WB-1:0]       are, aim;
	logic [PB-1:0]       mre, mim;
	logic [XW-1:0]       xre, xim;
	logic                ovr, ovi, sat_re, sat_im;
	logic [W-1:0]        sre, sim;
	cau_pkg::cau_side_t  side0;

	always_comb begin
		are = in_data.nre[WB-1] ? WB'(-in_data.nre) : WB'(in_data.nre);
		aim = in_data.nim[WB-1] ? WB'(-in_data.nim) : WB'(in_data.nim);
		mre = are[PB-1:0];
		mim = aim[PB-1:0];
		xre = in_data.recip ? (XW'(mre) << (2 * FRAC_BITS)) : (XW'(mre) << FRAC_BITS);
		xim = in_data.recip ? (XW'(mim) << (2 * FRAC_BITS)) : (XW'(mim) << FRAC_BITS);
		ovr = CW'(xre[XW-1:W+1]) >= CW'(in_data.d);
		ovi = CW'(xim[XW-1:W+1]) >= CW'(in_data.d);

		sat_re = 1'b1;
		if (in_data.wre > MAXW) begin
			sre = MAXV;
		end else if (in_data.wre < MINW) begin
			sre = MINV;
		end else begin
			sre    = in_data.wre[W-1:0];
			sat_re = 1'b0;
		end
		sat_im = 1'b1;
		if (in_data.wim > MAXW) begin
			sim = MAXV;
		end else if (in_data.wim < MINW) begin
			sim = MINV;
		end else begin
			sim    = in_data.wim[W-1:0];
			sat_im = 1'b0;
		end

		side0.is_div = in_data.is_div && !in_data.dz;
		side0.equal  = in_data.equal;
		if (in_data.is_div) begin
			side0.re     = '0;
			side0.im     = '0;
			side0.status = in_data.dz ? cau_pkg::ST_DZERO : cau_pkg::ST_OK;
		end else begin
			side0.re     = sre;
			side0.im     = sim;
			side0.status = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
	end

	// stage k of the arrays holds the state after k quotient bits
	logic                v_s4      [0:NS];
	cau_pkg::cau_side_t  side_s4   [0:NS];
	logic                neg_re_s4 [0:NS];
	logic                neg_im_s4 [0:NS];
	logic                ovf_re_s4 [0:NS];
	logic                ovf_im_s4 [0:NS];
	logic [PB-1:0]       rem_re_s4 [0:NS];
	logic [PB-1:0]       rem_im_s4 [0:NS];
	logic [W:0]          lo_re_s4  [0:NS];
	logic [W:0]          lo_im_s4  [0:NS];
	logic [W:0]          q_re_s4   [0:NS];
	logic [W:0]          q_im_s4   [0:NS];
	logic [PB-1:0]       d_s4      [0:NS];

	logic [PB-1:0]       tr_re [1:NS];
	logic [PB-1:0]       tr_im [1:NS];
	logic                ge_re [1:NS];
	logic                ge_im [1:NS];

	// trial subtract of one bit per stage
	always_comb begin
		for (int k = 1; k <= NS; k++) begin
			tr_re[k] = {rem_re_s4[k-1][PB-2:0], lo_re_s4[k-1][W]};
			tr_im[k] = {rem_im_s4[k-1][PB-2:0], lo_im_s4[k-1][W]};
			ge_re[k] = tr_re[k] >= d_s4[k-1];
			ge_im[k] = tr_im[k] >= d_s4[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++) begin
				v_s4[k] <= 1'b0;
			end
		end else if (en) begin
			v_s4[0] <= in_valid;
			for (int k = 1; k <= NS; k++) begin
				v_s4[k] <= v_s4[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4[0]   <= side0;
			neg_re_s4[0] <= in_data.nre[WB-1];
			neg_im_s4[0] <= in_data.nim[WB-1];
			ovf_re_s4[0] <= ovr;
			ovf_im_s4[0] <= ovi;
			rem_re_s4[0] <= PB'(xre[XW-1:W+1]);
			rem_im_s4[0] <= PB'(xim[XW-1:W+1]);
			lo_re_s4[0]  <= xre[W:0];
			lo_im_s4[0]  <= xim[W:0];
			q_re_s4[0]   <= '0;
			q_im_s4[0]   <= '0;
			d_s4[0]      <= in_data.d;
			for (int k = 1; k <= NS; k++) begin
				side_s4[k]   <= side_s4[k-1];
				neg_re_s4[k] <= neg_re_s4[k-1];
				neg_im_s4[k] <= neg_im_s4[k-1];
				ovf_re_s4[k] <= ovf_re_s4[k-1];
				ovf_im_s4[k] <= ovf_im_s4[k-1];
				rem_re_s4[k] <= ge_re[k] ? tr_re[k] - d_s4[k-1] : tr_re[k];
				rem_im_s4[k] <= ge_im[k] ? tr_im[k] - d_s4[k-1] : tr_im[k];
				lo_re_s4[k]  <= {lo_re_s4[k-1][W-1:0], 1'b0};
				lo_im_s4[k]  <= {lo_im_s4[k-1][W-1:0], 1'b0};
				q_re_s4[k]   <= {q_re_s4[k-1][W-1:0], ge_re[k]};
				q_im_s4[k]   <= {q_im_s4[k-1][W-1:0], ge_im[k]};
				d_s4[k]      <= d_s4[k-1];
			end
		end
	end

	assign out_valid    = v_s4[NS];
	assign out_side     = side_s4[NS];
	assign out_q.neg_re = neg_re_s4[NS];
	assign out_q.neg_im = neg_im_s4[NS];
	assign out_q.ovf_re = ovf_re_s4[NS];
	assign out_q.ovf_im = ovf_im_s4[NS];
	assign out_q.q_re   = q_re_s4[NS];
	assign out_q.q_im   = q_im_s4[NS];

endmodule

// ===== design/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: pipeline, result packing, output register.
// Depends on cau_pkg, cau_front, cau_div and complex_arithmetic_unit_defines.svh.
//
// Usage:
//   op channel (op_valid/op_ready/op) takes one beat per item: an action code
//   and two complex Q(32-FRAC_BITS).FRAC_BITS operands A and B.
//   res channel (res_valid/res_ready/res) returns exactly one beat per item,
//   in order: r_re, r_im, status (ok, divide by zero, saturated), equal.
// Timing:
//   Fully pipelined, one beat per cycle sustained for every action mix while
//   res_ready stays high. From acceptance to res_valid an item passes three front stages
//   (operand select, multipliers, sums), a divider setup stage, one stage per
//   quotient bit (WORD_BITS+1 of them, the restoring divider sets the depth)
//   and the output register. All actions take the same path and latency.
// Stalls:
//   The whole pipe advances when the output register is empty or taken;
//   while res_ready is low with a beat waiting, every stage holds and
//   op_ready drops, so no beat is lost or repeated.
// Reset:
//   arst_n clears all valid bits at once; the data registers have no reset,
//   and the block takes a beat in the first cycle after reset.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	input  cau_pkg::cau_in_t   op,
	output logic               res_valid,
	input  logic               res_ready,
	output cau_pkg::cau_out_t  res
);

	localparam int W = cau_pkg::WORD_BITS;

	localparam logic [W:0]   MAXQ = {2'b00, {(W-1){1'b1}}};
	localparam logic [W:0]   HALF = {2'b01, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	// Advance every stage when the output register is free or being drained.
	logic en;
	assign en       = !res_valid || res_ready;
	assign op_ready = en;

	logic              fe_valid;
	cau_pkg::cau_fe_t  fe_data;

	cau_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (op_valid),
		.in_data   (op),
		.out_valid (fe_valid),
		.out_data  (fe_data)
	);

	logic                dv_valid;
	cau_pkg::cau_side_t  dv_side;
	cau_pkg::cau_qt_t    dv_q;

	cau_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fe_valid),
		.in_data   (fe_data),
		.out_valid (dv_valid),
		.out_side  (dv_side),
		.out_q     (dv_q)
	);

	// Pack quotients: clamp to the word range, apply sign.
	logic               sat_re, sat_im;
	logic [W-1:0]       qre, qim;
	cau_pkg::cau_out_t  res_d;

	always_comb begin
		if (dv_q.neg_re) begin
			sat_re = dv_q.ovf_re || (dv_q.q_re > HALF);
			qre    = sat_re ? MINV : W'(-dv_q.q_re);
		end else begin
			sat_re = dv_q.ovf_re || (dv_q.q_re > MAXQ);
			qre    = sat_re ? MAXV : dv_q.q_re[W-1:0];
		end
		if (dv_q.neg_im) begin
			sat_im = dv_q.ovf_im || (dv_q.q_im > HALF);
			qim    = sat_im ? MINV : W'(-dv_q.q_im);
		end else begin
			sat_im = dv_q.ovf_im || (dv_q.q_im > MAXQ);
			qim    = sat_im ? MAXV : dv_q.q_im[W-1:0];
		end

		if (dv_side.is_div) begin
			res_d.r_re   = qre;
			res_d.r_im   = qim;
			res_d.status = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			res_d.equal  = 1'b0;
		end else begin
			res_d.r_re   = dv_side.re;
			res_d.r_im   = dv_side.im;
			res_d.status = dv_side.status;
			res_d.equal  = dv_side.equal;
		end
	end

	// Output register: hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= res_d;
		end
	end

	`CAU_ASSERT_NOW(a_dz_zero, res_valid && res.status == cau_pkg::ST_DZERO, res.r_re == '0 && res.r_im == '0, "divide by zero beat carries a nonzero result")
	`CAU_ASSERT_NOW(a_eq_clean, res_valid && res.equal, res.status == cau_pkg::ST_OK && res.r_re == '0 && res.r_im == '0, "compare beat carries a result or status")
	`CAU_ASSERT_NOW(a_sat_rail, res_valid && res.status == cau_pkg::ST_SAT, res.r_re == MAXV || res.r_re == MINV || res.r_im == MAXV || res.r_im == MINV, "saturated beat has no part at a rail")
	`CAU_ASSERT_NOW(a_stall_in, res_valid && !res_ready, !op_ready, "input taken while output stalled")
	`CAU_ASSERT_NEXT(a_pipe_hold, !op_ready, $stable(dv_valid), "pipeline moved during a stall")

endmodule

// ===== bench/complex_arithmetic_unit_test.sv =====
// Self-checking bench for complex_arithmetic_unit: directed and random operand beats,
// predicted in Q16.16 and compared field by field. Depends on cau_pkg and the block RTL.
module complex_arithmetic_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import cau_pkg::*;

	localparam int FRAC = 16;
	localparam int NUM_RANDOM = 1800;
	localparam int IDLE_LIMIT = 5000;

	// Holds predicted results in acceptance order and checks result beats against them.
	class result_scoreboard;
		cau_out_t expected_q[$];
		int errors = 0;

		function logic [31:0] clamp_word(input logic signed [129:0] v, inout bit sat);
			if (v > 130'sh7FFFFFFF) begin
				sat = 1;
				return 32'h7FFFFFFF;
			end
			if (v < -130'sh80000000) begin
				sat = 1;
				return 32'h80000000;
			end
			return v[31:0];
		endfunction

		// Truncating divide of |num| << sh by den, with the sign of num.
		function logic signed [129:0] div_trunc(input logic signed [69:0] num, input int sh,
				input logic [63:0] den);
			logic [127:0] mag;
			logic [127:0] q;
			logic signed [129:0] v;
			mag = (num < 0) ? 128'(-num) : 128'(num);
			q = (mag << sh) / {64'b0, den};
			v = {2'b00, q};
			return (num < 0) ? -v : v;
		endfunction

		function cau_out_t predict_result(input cau_in_t it);
			logic signed [69:0] ar, ai, br, bi, sre, sim;
			logic signed [129:0] vre, vim;
			logic [63:0] den;
			bit sat;
			bit dz;
			cau_out_t r;
			ar = $signed(it.a_re);
			ai = $signed(it.a_im);
			br = $signed(it.b_re);
			bi = $signed(it.b_im);
			vre = 0;
			vim = 0;
			sat = 0;
			dz = 0;
			r.equal = 1'b0;
			case (it.action)
				ACT_ADD: begin
					vre = ar + br;
					vim = ai + bi;
				end
				ACT_SUB: begin
					vre = ar - br;
					vim = ai - bi;
				end
				ACT_MUL, ACT_SQR: begin
					if (it.action == ACT_SQR) begin
						br = ar;
						bi = ai;
					end
					sre = ar * br - ai * bi;
					sim = ar * bi + ai * br;
					vre = sre >>> FRAC;
					vim = sim >>> FRAC;
				end
				ACT_DIV: begin
					den = 64'(br * br) + 64'(bi * bi);
					if (den == 0) dz = 1;
					else begin
						vre = div_trunc(ar * br + ai * bi, FRAC, den);
						vim = div_trunc(br * ai - ar * bi, FRAC, den);
					end
				end
				ACT_RECIP: begin
					den = 64'(ar * ar) + 64'(ai * ai);
					if (den == 0) dz = 1;
					else begin
						vre = div_trunc(ar, 2 * FRAC, den);
						vim = div_trunc(-ai, 2 * FRAC, den);
					end
				end
				ACT_NEG: begin
					vre = -ar;
					vim = -ai;
				end
				default: r.equal = (it.a_re == it.b_re) && (it.a_im == it.b_im);
			endcase
			r.r_re = clamp_word(vre, sat);
			r.r_im = clamp_word(vim, sat);
			r.status = dz ? ST_DZERO : (sat ? ST_SAT : ST_OK);
			return r;
		endfunction

		function void note_operands(input cau_in_t it);
			expected_q.push_back(predict_result(it));
		endfunction

		function void check_result(input cau_out_t got);
			cau_out_t exp_r;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: %p", got);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.r_re !== exp_r.r_re) begin
				$error("r_re expected %h actual %h", exp_r.r_re, got.r_re);
				errors++;
			end
			if (got.r_im !== exp_r.r_im) begin
				$error("r_im expected %h actual %h", exp_r.r_im, got.r_im);
				errors++;
			end
			if (got.status !== exp_r.status) begin
				$error("status expected %0d actual %0d", exp_r.status, got.status);
				errors++;
			end
			if (got.equal !== exp_r.equal) begin
				$error("equal expected %b actual %b", exp_r.equal, got.equal);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic op_valid = 1'b0;
	logic op_ready;
	cau_in_t op = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	cau_out_t res;

	result_scoreboard sb = new();
	int idle_cycles = 0;
	int rx_mode = 0;
	int rx_left = 0;

	complex_arithmetic_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_ready(op_ready),
		.op(op),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sample both channels at the rising edge; inputs only move at the falling edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (op_valid && op_ready) sb.note_operands(op);
			if (res_valid && res_ready) sb.check_result(res);
			if ((op_valid && op_ready) || (res_valid && res_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Receiver: switch at random times between stall patterns.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(16, 96);
		end
		rx_left--;
		case (rx_mode)
			0: res_ready <= 1'b1;
			1: res_ready <= $urandom_range(0, 1);
			2: res_ready <= ($urandom_range(0, 3) == 0);
			default: res_ready <= ($urandom_range(0, 15) != 0);
		endcase
	end

	// Drive one beat; call at a falling edge, returns at the falling edge after acceptance.
	task automatic send_beat(input cau_in_t it);
		op_valid <= 1'b1;
		op <= it;
		do @(posedge clk); while (!op_ready);
		@(negedge clk);
	endtask

	task automatic hold_idle(input int cycles);
		op_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic send_ops(input action_t act, input logic [31:0] ar, input logic [31:0] ai,
			input logic [31:0] br, input logic [31:0] bi);
		cau_in_t it;
		it.action = act;
		it.a_re = ar;
		it.a_im = ai;
		it.b_re = br;
		it.b_im = bi;
		send_beat(it);
	endtask

	// Mix of full-range, small, fixed-point-scaled and boundary operand parts.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
			3: return 32'($signed($urandom_range(0, 64)) - 32) << FRAC;
			4: return 32'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
			default: begin
				case ($urandom_range(0, 5))
					0: return 32'h80000000;
					1: return 32'h7FFFFFFF;
					2: return 32'h0;
					3: return 32'h00010000;
					4: return 32'hFFFFFFFF;
					default: return 32'hFFFF0000;
				endcase
			end
		endcase
	endfunction

	initial begin
		cau_in_t it;
		int burst;
		action_t act;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every action, boundary operands, zero divisors, min negate, compares.
		send_ops(ACT_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'hFFFFFFFF);
		send_ops(ACT_ADD, 32'h00010000, 32'h00020000, 32'hFFFF0000, 32'h00030000);
		send_ops(ACT_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h1, 32'hFFFFFFFF);
		send_ops(ACT_SUB, 32'h00050000, 32'h0, 32'h00020000, 32'h00010000);
		send_ops(ACT_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hFFFF0000);
		send_ops(ACT_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_ops(ACT_MUL, 32'hFFFFFFFF, 32'h0, 32'h00000001, 32'h0);
		send_ops(ACT_DIV, 32'h00010000, 32'h0, 32'h0, 32'h0);
		send_ops(ACT_DIV, 32'h00060000, 32'h00020000, 32'h00010000, 32'h00010000);
		send_ops(ACT_DIV, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000001, 32'h0);
		send_ops(ACT_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_ops(ACT_SQR, 32'h00030000, 32'h00020000, 32'h0, 32'h0);
		send_ops(ACT_SQR, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0);
		send_ops(ACT_RECIP, 32'h0, 32'h0, 32'h1, 32'h1);
		send_ops(ACT_RECIP, 32'h00020000, 32'h0, 32'h0, 32'h0);
		send_ops(ACT_RECIP, 32'h00000001, 32'hFFFFFFFF, 32'h0, 32'h0);
		send_ops(ACT_RECIP, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0);
		send_ops(ACT_NEG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
		send_ops(ACT_NEG, 32'h7FFFFFFF, 32'h00010000, 32'h0, 32'h0);
		send_ops(ACT_CMP, 32'h12345678, 32'h80000000, 32'h12345678, 32'h80000000);
		send_ops(ACT_CMP, 32'h12345678, 32'h80000000, 32'h12345678, 32'h80000001);
		send_ops(ACT_CMP, 32'hFFFFFFFF, 32'h0, 32'h7FFFFFFF, 32'h0);

		// Random: bursts of beats separated by gaps; back-to-back stretches included.
		burst = 0;
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n == NUM_RANDOM / 2) begin
				// Drain the pipe completely before going on.
				op_valid <= 1'b0;
				while (sb.expected_q.size() != 0) @(negedge clk);
			end
			if (burst == 0) begin
				if ($urandom_range(0, 3) != 0) hold_idle($urandom_range(1, 12));
				burst = $urandom_range(1, 60);
			end
			burst--;
			act = action_t'($urandom_range(0, 7));
			it.action = act;
			it.a_re = pick_word();
			it.a_im = pick_word();
			it.b_re = pick_word();
			it.b_im = pick_word();
			if ($urandom_range(0, 15) == 0) begin
				it.b_re = 0;
				it.b_im = 0;
				it.a_re = ($urandom_range(0, 1) != 0) ? 32'h0 : it.a_re;
				it.a_im = (it.a_re == 0) ? 32'h0 : it.a_im;
			end
			if (act == ACT_CMP && $urandom_range(0, 1) != 0) begin
				it.b_re = it.a_re;
				it.b_im = ($urandom_range(0, 2) != 0) ? it.a_im : (it.a_im ^ 32'h1);
			end
			send_beat(it);
		end

		// Let every outstanding result come back, then a margin for the pipe latency.
		op_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
